[hw/rtl/drrf_pkg.sv]
`default_nettype none
package drrf_pkg;

  localparam int NUM_PORTS_DFLT   = 24;
  localparam int QUEUE_DEPTH_DFLT = 4;

  localparam logic [7:0] ENABLE_MASK_RST = 8'h01;

  // Input function codes
  localparam logic [1:0] FUNC_SET    = 2'd0;
  localparam logic [1:0] FUNC_ENABLE = 2'd1;
  localparam logic [1:0] FUNC_REBOOT = 2'd2;
  localparam logic [1:0] FUNC_FLUSH  = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_LED_BASE    = 3'd0;
  localparam logic [2:0] REG_CTRL_ADDR   = 3'd1;
  localparam logic [2:0] REG_RESET_ADDR  = 3'd2;
  localparam logic [2:0] REG_RESET_START = 3'd3;
  localparam logic [2:0] REG_ENABLE_MASK = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SET,
    OP_ENABLE,
    OP_REBOOT,
    OP_FLUSH
  } cmd_op_t;

  // Decoded command passed from the front end through the queue
  typedef struct packed {
    cmd_op_t     op;
    logic [4:0]  port;
    logic [7:0]  data;       // level for a set, code for a reboot
    logic        enable_on;
  } cmd_t;

  typedef struct packed {
    logic [7:0] led_base_addr;
    logic [7:0] ctrl_addr;
    logic [7:0] reset_addr;
    logic [7:0] reset_start_code;
    logic [7:0] enable_mask;
  } cfg_t;

endpackage
`default_nettype wire

[hw/rtl/drrf_front.sv]
`default_nettype none
module drrf_front #(
  parameter int NUM_PORTS = drrf_pkg::NUM_PORTS_DFLT
) (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_func,
  input  wire logic [4:0]    in_port,
  input  wire logic [7:0]    in_new_level,
  input  wire logic          in_enable_on,
  input  wire logic [7:0]    in_reset_code,
  input  wire logic          q_full,
  output logic               q_push,
  output drrf_pkg::cmd_t     q_cmd
);
  import drrf_pkg::*;

  logic port_ok;

  assign port_ok  = ({1'b0, in_port} < 6'(NUM_PORTS));
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.port      = in_port;
    q_cmd.enable_on = in_enable_on;
    q_cmd.data      = in_new_level;
    q_cmd.op        = OP_NOP;
    case (in_func)
      FUNC_SET: begin
        // drop sets to ports that do not exist
        q_cmd.op = port_ok ? OP_SET : OP_NOP;
      end
      FUNC_ENABLE: q_cmd.op = OP_ENABLE;
      FUNC_REBOOT: begin
        q_cmd.op   = OP_REBOOT;
        q_cmd.data = in_reset_code;
      end
      FUNC_FLUSH: q_cmd.op = OP_FLUSH;
      default:    q_cmd.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/drrf_queue.sv]
`default_nettype none
module drrf_queue #(
  parameter int QUEUE_DEPTH = drrf_pkg::QUEUE_DEPTH_DFLT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire drrf_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output drrf_pkg::cmd_t      pop_cmd,
  output logic                empty
);
  import drrf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/drrf_back.sv]
`default_nettype none
module drrf_back #(
  parameter int NUM_PORTS = drrf_pkg::NUM_PORTS_DFLT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire drrf_pkg::cfg_t cfg,
  input  wire logic           q_empty,
  input  wire drrf_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_data_byte,
  output logic                out_write_start,
  output logic                out_last
);
  import drrf_pkg::*;

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam logic [NUM_PORTS-1:0] ONE_BIT = NUM_PORTS'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RST_A0,
    S_RST_C0,
    S_RST_A1,
    S_RST_C1,
    S_CTRL_A,
    S_CTRL_D,
    S_LED_A,
    S_LED_D
  } state_t;

  state_t               state_r;
  logic [7:0]           staged_r [NUM_PORTS];
  logic [7:0]           sent_r [NUM_PORTS];
  logic [NUM_PORTS-1:0] dirty_r;
  logic [NUM_PORTS-1:0] work_r;
  logic [IDX_W-1:0]     idx_r;
  logic [7:0]           ctrl_local_r;
  logic [7:0]           ctrl_sent_r;
  logic [7:0]           pend_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_start_r;
  logic                 out_last_r;

  logic                 slot_free;
  logic                 byte_load;
  logic [NUM_PORTS-1:0] low_onehot;
  logic [IDX_W-1:0]     first_idx;
  logic [IDX_W-1:0]     set_idx;
  logic [NUM_PORTS-1:0] work_left;

  assign slot_free       = !out_valid_r || out_ready;
  // every state other than idle loads one byte into the output register when the slot is free
  assign byte_load       = slot_free && (state_r != S_IDLE);
  assign q_pop           = (state_r == S_IDLE) && !q_empty;
  assign set_idx         = q_cmd.port[IDX_W-1:0];
  assign work_left       = work_r & ~(ONE_BIT << idx_r);
  assign out_valid       = out_valid_r;
  assign out_data_byte   = out_byte_r;
  assign out_write_start = out_start_r;
  assign out_last        = out_last_r;

  // lowest dirty port: isolate the lowest set bit, then encode it
  always_comb begin
    low_onehot = dirty_r & (~dirty_r + ONE_BIT);
    first_idx  = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (low_onehot[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dirty_r      <= '0;
      work_r       <= '0;
      idx_r        <= '0;
      ctrl_local_r <= '0;
      ctrl_sent_r  <= '0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      out_byte_r   <= '0;
      out_start_r  <= 1'b0;
      out_last_r   <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        staged_r[i] <= '0;
        sent_r[i]   <= '0;
      end
    end else begin
      if (byte_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            case (q_cmd.op)
              OP_SET: begin
                staged_r[set_idx] <= q_cmd.data;
                dirty_r[set_idx]  <= (q_cmd.data != sent_r[set_idx]);
              end
              OP_ENABLE: begin
                ctrl_local_r <= q_cmd.enable_on ? (ctrl_local_r | cfg.enable_mask)
                                                : (ctrl_local_r & ~cfg.enable_mask);
              end
              OP_REBOOT: pend_r <= q_cmd.data;
              OP_FLUSH: begin
                if (pend_r != '0) begin
                  state_r <= S_RST_A0;
                end else if (ctrl_local_r != ctrl_sent_r) begin
                  state_r <= S_CTRL_A;
                end else if (dirty_r != '0) begin
                  idx_r   <= first_idx;
                  work_r  <= dirty_r;
                  state_r <= S_LED_A;
                end
              end
              default: ;
            endcase
          end
        end
        S_RST_A0: begin
          if (slot_free) begin
            out_byte_r  <= cfg.reset_addr;
            out_start_r <= 1'b1;
            out_last_r  <= 1'b0;
            state_r     <= S_RST_C0;
          end
        end
        S_RST_C0: begin
          if (slot_free) begin
            out_byte_r  <= cfg.reset_start_code;
            out_start_r <= 1'b0;
            out_last_r  <= 1'b0;
            state_r     <= S_RST_A1;
          end
        end
        S_RST_A1: begin
          if (slot_free) begin
            out_byte_r  <= cfg.reset_addr;
            out_start_r <= 1'b1;
            out_last_r  <= 1'b0;
            state_r     <= S_RST_C1;
          end
        end
        S_RST_C1: begin
          if (slot_free) begin
            out_byte_r  <= pend_r;
            out_start_r <= 1'b0;
            out_last_r  <= 1'b1;
            pend_r      <= '0;
            state_r     <= S_IDLE;
          end
        end
        S_CTRL_A: begin
          if (slot_free) begin
            out_byte_r  <= cfg.ctrl_addr;
            out_start_r <= 1'b1;
            out_last_r  <= 1'b0;
            state_r     <= S_CTRL_D;
          end
        end
        S_CTRL_D: begin
          if (slot_free) begin
            out_byte_r  <= ctrl_local_r;
            out_start_r <= 1'b0;
            out_last_r  <= (dirty_r == '0);
            ctrl_sent_r <= ctrl_local_r;
            idx_r       <= first_idx;
            work_r      <= dirty_r;
            state_r     <= (dirty_r == '0) ? S_IDLE : S_LED_A;
          end
        end
        S_LED_A: begin
          if (slot_free) begin
            out_byte_r  <= 8'(cfg.led_base_addr + 8'(idx_r));
            out_start_r <= 1'b1;
            out_last_r  <= 1'b0;
            state_r     <= S_LED_D;
          end
        end
        S_LED_D: begin
          if (slot_free) begin
            out_byte_r    <= staged_r[idx_r];
            out_start_r   <= 1'b0;
            out_last_r    <= (work_left == '0);
            sent_r[idx_r] <= staged_r[idx_r];
            work_r        <= work_left;
            // walk every port up to the highest dirty one
            if (work_left == '0) begin
              dirty_r <= '0;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dirty_range_register_flusher.sv]
// Dirty-range register flusher. Items on the in_ channel stage output levels, change the
// enable bits of the control byte, request a device reset or ask for a flush; a flush puts out
// the bytes of the bus writes that bring the device up to date, one byte per out_ transfer, with
// out_write_start on each address byte and out_last on the final byte of that flush (a flush with
// nothing to send puts out nothing). Items enter a QUEUE_DEPTH-entry command queue at one per
// cycle while it has room. The executing state machine takes one queued command per cycle while
// idle for set, enable and reset-request items; a flush sends its bytes one at a time through the
// single output register, waiting whenever out_ready is held low: 4 bytes for a pending reset,
// otherwise up to 2 control bytes plus 1 address byte and one byte per port from the first to the
// last dirty port. Registers sit on an APB port at byte addresses 0x00 led_base_addr, 0x04
// ctrl_addr, 0x08 reset_addr, 0x0C reset_start_code, 0x10 enable_mask; write them only while
// the block is idle.
`default_nettype none
module dirty_range_register_flusher #(
  parameter int NUM_PORTS   = drrf_pkg::NUM_PORTS_DFLT,
  parameter int QUEUE_DEPTH = drrf_pkg::QUEUE_DEPTH_DFLT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [4:0]  in_port,
  input  wire logic [7:0]  in_new_level,
  input  wire logic        in_enable_on,
  input  wire logic [7:0]  in_reset_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_data_byte,
  output logic             out_write_start,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import drrf_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic [7:0] rd_byte;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = {24'd0, rd_byte};

  always_comb begin
    case (reg_idx)
      REG_LED_BASE:    rd_byte = cfg_r.led_base_addr;
      REG_CTRL_ADDR:   rd_byte = cfg_r.ctrl_addr;
      REG_RESET_ADDR:  rd_byte = cfg_r.reset_addr;
      REG_RESET_START: rd_byte = cfg_r.reset_start_code;
      REG_ENABLE_MASK: rd_byte = cfg_r.enable_mask;
      default:         rd_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_base_addr    <= '0;
      cfg_r.ctrl_addr        <= '0;
      cfg_r.reset_addr       <= '0;
      cfg_r.reset_start_code <= '0;
      cfg_r.enable_mask      <= ENABLE_MASK_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LED_BASE:    cfg_r.led_base_addr    <= pwdata[7:0];
        REG_CTRL_ADDR:   cfg_r.ctrl_addr        <= pwdata[7:0];
        REG_RESET_ADDR:  cfg_r.reset_addr       <= pwdata[7:0];
        REG_RESET_START: cfg_r.reset_start_code <= pwdata[7:0];
        REG_ENABLE_MASK: cfg_r.enable_mask      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  drrf_front #(
    .NUM_PORTS (NUM_PORTS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_port       (in_port),
    .in_new_level  (in_new_level),
    .in_enable_on  (in_enable_on),
    .in_reset_code (in_reset_code),
    .q_full        (full),
    .q_push        (push),
    .q_cmd         (push_cmd)
  );

  drrf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  drrf_back #(
    .NUM_PORTS (NUM_PORTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (empty),
    .q_cmd           (pop_cmd),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_write_start (out_write_start),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

[bench/dirty_range_register_flusher_test.sv]
module dirty_range_register_flusher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import drrf_pkg::*;

  localparam int NPORTS = NUM_PORTS_DFLT;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 58;
  localparam int NUM_PHASES = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } bus_byte_t;

  // One input item; fixed_exp marks rows whose bytes are written out by hand
  typedef struct packed {
    logic [1:0]      func;
    logic [4:0]      port;
    logic [7:0]      level;
    logic            en;
    logic [7:0]      code;
    logic            fixed_exp;
    logic [2:0]      n_fixed;
    bus_byte_t [0:3] fixed_bytes;
  } row_t;

  // Directed items, run with led base F0, ctrl 55, reset AA, start code 5A, enable mask 81.
  // Hand-written bytes are {data, 2'b<start><last>}.
  localparam row_t DIRECTED_ITEMS [25] = '{
    '{FUNC_FLUSH,  5'd31, 8'hFF, 1'b1, 8'hFF, 1'b1, 3'd0, 40'd0},
    '{FUNC_SET,    5'd0,  8'hFF, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b1, 3'd2,
      {8'hF0, 2'b10, 8'hFF, 2'b01, 20'd0}},
    '{FUNC_SET,    5'd31, 8'hAB, 1'b1, 8'hFF, 1'b0, 3'd0, 40'd0},
    '{FUNC_SET,    5'd24, 8'h12, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b1, 3'd0, 40'd0},
    '{FUNC_ENABLE, 5'd31, 8'hFF, 1'b1, 8'hFF, 1'b0, 3'd0, 40'd0},
    '{FUNC_SET,    5'd23, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_SET,    5'd5,  8'h80, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_REBOOT, 5'd0,  8'h00, 1'b0, 8'h3C, 1'b0, 3'd0, 40'd0},
    '{FUNC_SET,    5'd2,  8'h10, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b1, 3'd4,
      {8'hAA, 2'b10, 8'h5A, 2'b00, 8'hAA, 2'b10, 8'h3C, 2'b01}},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_REBOOT, 5'd31, 8'hFF, 1'b1, 8'hFF, 1'b0, 3'd0, 40'd0},
    '{FUNC_REBOOT, 5'd0,  8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b1, 3'd0, 40'd0},
    '{FUNC_SET,    5'd7,  8'h33, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_SET,    5'd7,  8'h00, 1'b1, 8'hFF, 1'b0, 3'd0, 40'd0},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b1, 3'd0, 40'd0},
    '{FUNC_ENABLE, 5'd31, 8'hFF, 1'b0, 8'hFF, 1'b0, 3'd0, 40'd0},
    '{FUNC_SET,    5'd23, 8'hFF, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b1, 3'd4,
      {8'h55, 2'b10, 8'h00, 2'b00, 8'h07, 2'b10, 8'hFF, 2'b01}},
    '{FUNC_REBOOT, 5'd0,  8'h00, 1'b0, 8'h01, 1'b0, 3'd0, 40'd0},
    '{FUNC_FLUSH,  5'd0,  8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 40'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = '0;
  logic [4:0]  in_port = '0;
  logic [7:0]  in_new_level = '0;
  logic        in_enable_on = 1'b0;
  logic [7:0]  in_reset_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_write_start;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dirty_range_register_flusher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_port         (in_port),
    .in_new_level    (in_new_level),
    .in_enable_on    (in_enable_on),
    .in_reset_code   (in_reset_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_write_start (out_write_start),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the device view: registers, staged and sent levels, control, reset request
  cfg_t              dev_cfg;
  logic [7:0]        staged_lvl [NPORTS];
  logic [7:0]        sent_lvl [NPORTS];
  logic [NPORTS-1:0] dirty_ports;
  logic [7:0]        ctrl_local;
  logic [7:0]        ctrl_sent;
  logic [7:0]        reset_pending;

  bus_byte_t flush_bytes [$];
  bus_byte_t bytes_due [$];
  bus_byte_t byte_want;

  int  byte_errors = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  int  rx_hold = 0;
  bit  rx_calm = 1'b0;
  bit  tx_calm = 1'b0;

  task automatic emit(input logic [7:0] data, input logic start);
    bus_byte_t b;
    b.data = data;
    b.start = start;
    b.last = 1'b0;
    flush_bytes.push_back(b);
  endtask

  // Update the shadow for one accepted item; a flush leaves its bytes in flush_bytes
  task automatic advance_shadow(input row_t r);
    int first_p;
    int last_p;
    logic [7:0] addr;
    flush_bytes.delete();
    case (r.func)
      FUNC_SET: begin
        if (r.port < NPORTS) begin
          staged_lvl[r.port] = r.level;
          dirty_ports[r.port] = (r.level != sent_lvl[r.port]);
        end
      end
      FUNC_ENABLE: begin
        if (r.en)
          ctrl_local = ctrl_local | dev_cfg.enable_mask;
        else
          ctrl_local = ctrl_local & ~dev_cfg.enable_mask;
      end
      FUNC_REBOOT: begin
        reset_pending = r.code;
      end
      default: begin
        if (reset_pending != 8'd0) begin
          // reset sequence only; control and levels stay stale
          emit(dev_cfg.reset_addr, 1'b1);
          emit(dev_cfg.reset_start_code, 1'b0);
          emit(dev_cfg.reset_addr, 1'b1);
          emit(reset_pending, 1'b0);
          reset_pending = 8'd0;
        end else begin
          if (ctrl_sent != ctrl_local) begin
            emit(dev_cfg.ctrl_addr, 1'b1);
            emit(ctrl_local, 1'b0);
            ctrl_sent = ctrl_local;
          end
          if (dirty_ports != '0) begin
            first_p = -1;
            last_p = -1;
            for (int p = 0; p < NPORTS; p++) begin
              if (dirty_ports[p]) begin
                if (first_p < 0) first_p = p;
                last_p = p;
              end
            end
            addr = dev_cfg.led_base_addr + 8'(first_p);
            emit(addr, 1'b1);
            for (int p = first_p; p <= last_p; p++) begin
              sent_lvl[p] = staged_lvl[p];
              emit(staged_lvl[p], 1'b0);
            end
            dirty_ports = '0;
          end
        end
        if (flush_bytes.size() > 0) flush_bytes[$].last = 1'b1;
      end
    endcase
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic row_t rand_row(input logic [1:0] func);
    row_t r;
    r = '0;
    r.func = func;
    r.port = 5'($urandom_range(0, 31));
    r.level = 8'($urandom);
    r.en = 1'($urandom);
    r.code = 8'($urandom);
    return r;
  endfunction

  // Hold the item until the transfer, then queue what it should produce
  task automatic push_item(input row_t r);
    in_valid <= 1'b1;
    in_func <= r.func;
    in_port <= r.port;
    in_new_level <= r.level;
    in_enable_on <= r.en;
    in_reset_code <= r.code;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    advance_shadow(r);
    if (r.fixed_exp) begin
      for (int k = 0; k < r.n_fixed; k++) bytes_due.push_back(r.fixed_bytes[k]);
    end else begin
      foreach (flush_bytes[k]) bytes_due.push_back(flush_bytes[k]);
    end
  endtask

  task automatic sender_gap();
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected byte, then let queued non-flush items retire
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_registers(input cfg_t c);
    logic [7:0] vals [5];
    vals[REG_LED_BASE] = c.led_base_addr;
    vals[REG_CTRL_ADDR] = c.ctrl_addr;
    vals[REG_RESET_ADDR] = c.reset_addr;
    vals[REG_RESET_START] = c.reset_start_code;
    vals[REG_ENABLE_MASK] = c.enable_mask;
    pwrite <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      paddr <= {3'(i), 2'b00};
      pwdata <= {24'd0, vals[i]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    dev_cfg = c;
  endtask

  task automatic sweep_ports();
    row_t r;
    push_item(rand_row(FUNC_ENABLE));
    sender_gap();
    for (int p = 0; p < NPORTS; p++) begin
      r = rand_row(FUNC_SET);
      r.port = 5'(p);
      push_item(r);
      sender_gap();
    end
    push_item(rand_row(FUNC_FLUSH));
    sender_gap();
  endtask

  // A few level updates, maybe an enable or reset request, closed by a flush
  task automatic run_update_burst();
    row_t r;
    int n;
    int roll;
    n = $urandom_range(0, 5);
    repeat (n) begin
      r = rand_row(FUNC_SET);
      roll = $urandom_range(0, 99);
      if (roll < 10) r.port = 5'($urandom_range(NPORTS, 31));
      else r.port = 5'($urandom_range(0, NPORTS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 25 && r.port < NPORTS) r.level = sent_lvl[r.port];
      else if (roll < 35) r.level = 8'h00;
      else if (roll < 45) r.level = 8'hFF;
      push_item(r);
      sender_gap();
    end
    if ($urandom_range(0, 99) < 20) begin
      push_item(rand_row(FUNC_ENABLE));
      sender_gap();
    end
    if ($urandom_range(0, 99) < 15) begin
      r = rand_row(FUNC_REBOOT);
      if ($urandom_range(0, 4) == 0) r.code = 8'h00;
      push_item(r);
      sender_gap();
    end
    push_item(rand_row(FUNC_FLUSH));
    sender_gap();
    if ($urandom_range(0, 19) == 0) drain_and_settle();
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      push_item(rand_row(2'($urandom_range(0, 3))));
      sender_gap();
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          out_ready <= 1'b0;
          rx_hold <= $urandom_range(0, 3);
        end
        4: begin
          out_ready <= 1'b0;
          rx_hold <= $urandom_range(10, 40);
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got data %h start %b last %b",
                 $time, out_data_byte, out_write_start, out_last);
        byte_errors++;
      end else begin
        byte_want = bytes_due.pop_front();
        if (out_data_byte !== byte_want.data || out_write_start !== byte_want.start ||
            out_last !== byte_want.last) begin
          $display("%0t: byte mismatch: expected data %h start %b last %b,",
                   $time, byte_want.data, byte_want.start, byte_want.last,
                   " got data %h start %b last %b",
                   out_data_byte, out_write_start, out_last);
          byte_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cfg_t phase_cfg;
    int phase_start;
    int roll;
    dev_cfg = '0;
    dev_cfg.enable_mask = ENABLE_MASK_RST;
    foreach (staged_lvl[p]) begin
      staged_lvl[p] = 8'd0;
      sent_lvl[p] = 8'd0;
    end
    dirty_ports = '0;
    ctrl_local = 8'd0;
    ctrl_sent = 8'd0;
    reset_pending = 8'd0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    phase_cfg.led_base_addr = 8'hF0;
    phase_cfg.ctrl_addr = 8'h55;
    phase_cfg.reset_addr = 8'hAA;
    phase_cfg.reset_start_code = 8'h5A;
    phase_cfg.enable_mask = 8'h81;
    load_registers(phase_cfg);
    foreach (DIRECTED_ITEMS[i]) begin
      push_item(DIRECTED_ITEMS[i]);
      sender_gap();
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_and_settle();
      tx_calm = (phase == 2);
      rx_calm = (phase == 2);
      if (phase == 0) begin
        phase_cfg = '0;
      end else if (phase == 1) begin
        phase_cfg = '1;
      end else begin
        phase_cfg.led_base_addr = 8'($urandom);
        phase_cfg.ctrl_addr = 8'($urandom);
        phase_cfg.reset_addr = 8'($urandom);
        phase_cfg.reset_start_code = 8'($urandom);
        phase_cfg.enable_mask = 8'($urandom);
      end
      load_registers(phase_cfg);
      phase_start = items_sent;
      sweep_ports();
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) run_update_burst();
        else if (roll < 95) run_noise();
        else sweep_ports();
      end
    end

    drain_and_settle();
    if (byte_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/drrf_pkg.sv
hw/rtl/drrf_front.sv
hw/rtl/drrf_queue.sv
hw/rtl/drrf_back.sv
hw/rtl/dirty_range_register_flusher.sv
bench/dirty_range_register_flusher_test.sv
